/* src/mcpst_pkg.sv */
package mcpst_pkg;

    localparam int MAX_CAMERAS = 4;
    localparam int MAX_HALF    = 16;
    localparam int CHANNELS    = 4;

    localparam int PATCH_DEPTH = 4 * MAX_HALF * MAX_HALF;
    localparam int ADDR_W      = $clog2(PATCH_DEPTH);
    localparam int AREA_W      = $clog2(PATCH_DEPTH + 1);
    localparam int CAM_W       = $clog2(MAX_CAMERAS);
    localparam int ECAM_W      = $clog2(MAX_CAMERAS + 1);
    localparam int HALF_W      = $clog2(MAX_HALF + 1);

    localparam int CAMF_W      = 3;
    localparam int HALFF_W     = 5;
    localparam int THR_W       = 16;
    localparam int SUM_W       = 22;
    localparam int PIX_W       = 8;
    localparam int WORD_W      = 4 * PIX_W;
    localparam int OUT_DW      = ((SUM_W + 7) / 8) * 8;
    localparam int DIFF_W      = $clog2(255 * CHANNELS + 1);
    localparam int CHN_W       = $clog2(CHANNELS + 1);
    localparam int GEO_W       = AREA_W + CAM_W;
    localparam int RHS_W       = THR_W + GEO_W + CHN_W;
    localparam int LHS_W       = SUM_W + 8;
    localparam int CMP_W       = (RHS_W > LHS_W) ? RHS_W : LHS_W;

    localparam int CFG_DW      = 32;
    localparam int CFG_AW      = 4;

    localparam logic [1:0] REG_CAMERA_COUNT = 2'd0;
    localparam logic [1:0] REG_PATCH_HALF   = 2'd1;
    localparam logic [1:0] REG_THRESHOLD    = 2'd2;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic              restart;
        logic [CAM_W-1:0]  cams_m1;
        logic [ADDR_W-1:0] area_m1;
        logic [RHS_W-1:0]  rhs;
    } t_geom;

    typedef struct packed {
        logic              valid;
        logic              cmp;
        logic              last;
        logic [WORD_W-1:0] word;
    } t_pix;

    typedef struct packed {
        logic              valid;
        logic              cmp;
        logic              last;
        logic [DIFF_W-1:0] diff;
    } t_diff;

    typedef struct packed {
        logic             valid;
        logic             busy_last;
        logic [SUM_W-1:0] sum;
    } t_fin;

    function automatic logic [ECAM_W-1:0] eff_cams(input logic [CAMF_W-1:0] v);
        logic [ECAM_W-1:0] r;
        if (v < CAMF_W'(2)) begin
            r = ECAM_W'(2);
        end else if (32'(v) > MAX_CAMERAS) begin
            r = ECAM_W'(MAX_CAMERAS);
        end else begin
            r = ECAM_W'(v);
        end
        return r;
    endfunction

    function automatic logic [HALF_W-1:0] eff_half(input logic [HALFF_W-1:0] v);
        logic [HALF_W-1:0] r;
        if (v == '0) begin
            r = HALF_W'(1);
        end else if (32'(v) > MAX_HALF) begin
            r = HALF_W'(MAX_HALF);
        end else begin
            r = HALF_W'(v);
        end
        return r;
    endfunction

    function automatic logic [AREA_W-1:0] area_of(input logic [HALF_W-1:0] h);
        logic [2*HALF_W-1:0] sq;
        sq = (2*HALF_W)'(h) * (2*HALF_W)'(h);
        return AREA_W'({sq, 2'b00});
    endfunction

endpackage

/* src/mcpst_cfg.sv */
module mcpst_cfg
    import mcpst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_geom             o_geom
);

    logic [CAMF_W-1:0]  r_cam_count;
    logic [HALFF_W-1:0] r_patch_half;
    logic [THR_W-1:0]   r_threshold;
    logic [AREA_W-1:0]  r_area;
    logic [GEO_W-1:0]   r_geo;
    logic [RHS_W-1:0]   r_prod;
    logic [RHS_W-1:0]   r_rhs;

    logic              wr;
    logic [1:0]        idx;
    logic [AREA_W-1:0] area;
    logic [ECAM_W-1:0] ecams;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_count  <= CAMF_W'(2);
            r_patch_half <= HALFF_W'(4);
            r_threshold  <= '0;
        end else if (wr) begin
            unique case (idx)
                REG_CAMERA_COUNT: r_cam_count  <= pwdata[CAMF_W-1:0];
                REG_PATCH_HALF:   r_patch_half <= pwdata[HALFF_W-1:0];
                REG_THRESHOLD:    r_threshold  <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CAMERA_COUNT: prdata = CFG_DW'(r_cam_count);
            REG_PATCH_HALF:   prdata = CFG_DW'(r_patch_half);
            REG_THRESHOLD:    prdata = CFG_DW'(r_threshold);
            default:          prdata = '0;
        endcase
    end

    assign ecams = eff_cams(r_cam_count);
    assign area  = area_of(eff_half(r_patch_half));

    // Threshold product: after a write it is registered through r_area, r_geo, r_prod and r_rhs in turn
    always_ff @(posedge i_clk) begin
        r_area <= area;
        r_geo  <= GEO_W'(r_area) * GEO_W'(o_geom.cams_m1);
        r_prod <= RHS_W'(r_threshold) * RHS_W'(r_geo);
        r_rhs  <= r_prod * RHS_W'(CHANNELS);
    end

    assign o_geom.restart = wr && ((idx == REG_CAMERA_COUNT) || (idx == REG_PATCH_HALF));
    assign o_geom.cams_m1 = CAM_W'(ecams - ECAM_W'(1));
    assign o_geom.area_m1 = ADDR_W'(area - AREA_W'(1));
    assign o_geom.rhs     = r_rhs;

endmodule

/* src/mcpst_patch_mem.sv */
module mcpst_patch_mem
    import mcpst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WORD_W-1:0] i_wdata,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [PATCH_DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/mcpst_sad.sv */
module mcpst_sad
    import mcpst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  t_pix              i_s1,
    input  logic [WORD_W-1:0] i_rdata,
    output t_fin              o_fin
);

    t_diff              r_s2;
    logic [SUM_W-1:0]   r_sum;
    logic               r_fin_valid;
    logic [SUM_W-1:0]   r_fin_sum;

    logic [DIFF_W-1:0]  diff;
    logic [SUM_W:0]     wide;
    logic [SUM_W-1:0]   n_sum;

    always_comb begin
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        diff = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            a = i_s1.word[PIX_W*k +: PIX_W];
            b = i_rdata[PIX_W*k +: PIX_W];
            diff = diff + DIFF_W'((a > b) ? (a - b) : (b - a));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= i_s1.valid;
        end
        r_s2.cmp  <= i_s1.cmp;
        r_s2.last <= i_s1.last;
        r_s2.diff <= diff;
    end

    // Saturate as a guard; the clamped geometry keeps the sum well below it
    assign wide  = (SUM_W+1)'(r_sum) + (SUM_W+1)'(r_s2.cmp ? r_s2.diff : DIFF_W'(0));
    assign n_sum = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= r_s2.valid && r_s2.last;
            if (i_restart) begin
                r_sum <= '0;
            end else if (r_s2.valid) begin
                r_sum <= r_s2.last ? '0 : n_sum;
            end
        end
        if (r_s2.valid && r_s2.last) begin
            r_fin_sum <= n_sum;
        end
    end

    assign o_fin.valid     = r_fin_valid;
    assign o_fin.busy_last = r_fin_valid || (r_s2.valid && r_s2.last);
    assign o_fin.sum       = r_fin_sum;

endmodule

/* src/multi_camera_patch_sad_trigger_core.sv */
// Result path: stage 1, difference register, final-sum register, then the output register to m_axis.
// Throughput: one pixel per cycle; the only hold is on a frame's last pixel while the previous
// frame's result still waits on m_axis (or is on its way to the output register).
// Reset: synchronous, active low; counters, running sum and flags clear, registers return to
// camera_count 2, patch_half 4, threshold 0. The base patch memory is not cleared.
module multi_camera_patch_sad_trigger_core
    import mcpst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,   // chan_a, chan_b, chan_c, chan_d
    input  logic              s_axis_tuser,   // in_view
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // difference_sum, zero padding
    output logic              m_axis_tuser,   // activated
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    t_geom              geom;
    t_pix               r_s1;
    t_fin               fin;

    logic [ADDR_W-1:0]  r_pix;
    logic [CAM_W-1:0]   r_cam;
    logic               r_out_valid;
    logic               r_out_act;
    logic [SUM_W-1:0]   r_out_sum;

    logic               at_last_pix;
    logic               at_last;
    logic               accept;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  rdata;
    logic [CMP_W-1:0]   lhs;

    mcpst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (geom)
    );

    // Position within the frame, taken straight from the live registers
    assign at_last_pix = (r_pix == geom.area_m1);
    assign at_last     = at_last_pix && (r_cam == geom.cams_m1);

    // Hold the frame-ending pixel until the result path is clear, so no result is ever dropped
    assign s_axis_tready = !(at_last && (r_out_valid || (r_s1.valid && r_s1.last) ||
                                         fin.busy_last));
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Drop the channels of a pixel outside the image
    assign word = s_axis_tuser ? s_axis_tdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
            r_cam <= '0;
        end else if (geom.restart) begin
            r_pix <= '0;
            r_cam <= '0;
        end else if (accept) begin
            if (at_last_pix) begin
                r_pix <= '0;
                r_cam <= at_last ? '0 : r_cam + CAM_W'(1);
            end else begin
                r_pix <= r_pix + ADDR_W'(1);
            end
        end
    end

    // Camera 0 writes the base patch; every later camera reads the same position back
    mcpst_patch_mem u_mem (
        .i_clk   (i_clk),
        .i_wr_en (accept && (r_cam == '0)),
        .i_rd_en (accept && (r_cam != '0)),
        .i_addr  (r_pix),
        .i_wdata (word),
        .o_rdata (rdata)
    );

    // Stage 1: hold the pixel alongside the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= accept;
        end
        r_s1.cmp  <= (r_cam != '0);
        r_s1.last <= at_last;
        r_s1.word <= word;
    end

    mcpst_sad u_sad (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (geom.restart),
        .i_s1      (r_s1),
        .i_rdata   (rdata),
        .o_fin     (fin)
    );

    // Mean test without division: total*256 against threshold*channels*area*(cameras-1)
    assign lhs = CMP_W'({fin.sum, 8'h00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (fin.valid) begin
            r_out_sum <= fin.sum;
            r_out_act <= (lhs < CMP_W'(geom.rhs));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DW'(r_out_sum);
    assign m_axis_tuser  = r_out_act;

    // A finished result never lands on a result still waiting for transfer
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin.valid |-> !r_out_valid)
        else $error("result reached a full output register");

    // At most one frame end anywhere between input and output
    a_one_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_s1.valid && r_s1.last, fin.busy_last && !fin.valid, fin.valid,
                  r_out_valid}))
        else $error("more than one frame end in flight");

    // Pixel position stays inside the patch
    a_pix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && at_last_pix |=> (r_pix == '0) || $past(geom.restart))
        else $error("pixel counter failed to wrap at the end of a patch");

endmodule
